[rtl/rrts_pkg.sv]
// round robin task scheduler shared package
// command, task state and status codes, structs between controller and datapath
`timescale 1ns / 1ps
package rrts_pkg;

   typedef enum logic [2:0] {
      CMD_ADD    = 3'd0,
      CMD_NEXT   = 3'd1,
      CMD_YIELD  = 3'd2,
      CMD_SLEEP  = 3'd3,
      CMD_WAKEUP = 3'd4,
      CMD_EXIT   = 3'd5
   } cmd_type;

   typedef enum logic [2:0] {
      TS_FREE   = 3'd0,
      TS_NEW    = 3'd1,
      TS_READY  = 3'd2,
      TS_ACTIVE = 3'd3,
      TS_SLEEP  = 3'd4,
      TS_EXITED = 3'd5
   } tstate_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_NONE_RUN = 2'd1,
      STAT_FULL     = 2'd2,
      STAT_BAD      = 2'd3
   } status_type;

   typedef struct packed {
      logic       latch;
      logic       add_fresh;
      logic       fs_pop;
      logic       id_from_fs;
      logic       walk_start;
      logic       rq_pop;
      logic       ts_rd;
      logic       ts_rd_rq;
      logic       id_from_rq;
      logic       ts_wr;
      tstate_type ts_wr_val;
      logic       q_push;
      logic       fs_push;
      logic       live_inc;
      logic       live_dec;
      logic       res_set;
      logic       res_found;
      status_type res_status;
      logic       rsp_load;
   } ctl_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic       tid_ok;
      logic       live_full;
      logic       fs_empty;
      logic       fresh_ok;
      logic       budget_zero;
      logic       cur_ok;
      tstate_type st;
   } sts_type;

endpackage

[rtl/round_robin_task_scheduler.sv]
// round robin task scheduler top level: controller plus datapath
// depends on rrts_pkg, rrts_ctrl, rrts_dpath
//
//   channel  dir  fields                                                 transfer
//   req      in   req_command, req_task_id                               req_valid & req_ready
//   rsp      out  rsp_result_id, rsp_found, rsp_status, rsp_no_tasks_live rsp_valid & rsp_ready
//
// one item at a time, from the accepting cycle through decode to the output register load
// add: decode to done when full, via the write state with a fresh id, via the free stack
// pop state and the write state with a reused id; yield/sleep/wakeup/exit via the check
// state, a bad id or an unknown command decode to done; next walks the queue, each entry via
// the loop, id and state steps, set by the single read port of the queue and task state memories
// the next item is taken as soon as the result sits in the output register; a stalled rsp
// holds the finished result and the sequencer in its last state
// synchronous reset, no clearing pass
`timescale 1ns / 1ps
module round_robin_task_scheduler #(
   parameter int MAX_TASKS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_command,
   input  logic [4:0] req_task_id,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [4:0] rsp_result_id,
   output logic       rsp_found,
   output logic [1:0] rsp_status,
   output logic       rsp_no_tasks_live
);

   rrts_pkg::ctl_type ctl;
   rrts_pkg::sts_type sts;

   rrts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   rrts_dpath #(
      .MAX_TASKS (MAX_TASKS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .sts               (sts),
      .req_command       (req_command),
      .req_task_id       (req_task_id),
      .rsp_result_id     (rsp_result_id),
      .rsp_found         (rsp_found),
      .rsp_status        (rsp_status),
      .rsp_no_tasks_live (rsp_no_tasks_live)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("accepted a transfer while busy");

   a_found_has_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_result_id != 5'd0)
      else $error("found result with zero id");

   a_none_run_not_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == rrts_pkg::STAT_NONE_RUN |-> !rsp_found)
      else $error("nothing runnable but found set");

   a_no_load_over_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("held result dropped");

endmodule

[rtl/rrts_dpath.sv]
// scheduler datapath: task state, run queue and free stack memories, counters
// depends on rrts_pkg
`timescale 1ns / 1ps
module rrts_dpath #(
   parameter int MAX_TASKS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  rrts_pkg::ctl_type  ctl,
   output rrts_pkg::sts_type  sts,
   input  logic [2:0]         req_command,
   input  logic [4:0]         req_task_id,
   output logic [4:0]         rsp_result_id,
   output logic               rsp_found,
   output logic [1:0]         rsp_status,
   output logic               rsp_no_tasks_live
);

   localparam int IDW = $clog2(MAX_TASKS + 1);
   localparam int IX  = (MAX_TASKS > 2) ? $clog2(MAX_TASKS) : 1;
   localparam int CW  = $clog2(MAX_TASKS + 1);
   localparam int FW  = $clog2(MAX_TASKS + 2);
   localparam int TW  = (IDW > 5) ? IDW : 5;

   logic [IDW-1:0] rq_mem [MAX_TASKS];
   logic [IDW-1:0] fs_mem [MAX_TASKS];
   logic [2:0]     ts_mem [MAX_TASKS];
   logic [MAX_TASKS-1:0] ts_valid_ff;

   logic [2:0]     cmd_ff;
   logic           tid_ok_ff;
   logic [IDW-1:0] cur_id_ff;
   logic [IX-1:0]  head_ff, tail_ff;
   logic [CW-1:0]  qcount_ff, fcount_ff, live_ff, budget_ff;
   logic [FW-1:0]  fresh_ff;
   logic [IDW-1:0] rq_rdata_ff, fs_rdata_ff;
   logic [2:0]     ts_rdata_ff;
   logic           ts_rvalid_ff;
   logic [IDW-1:0] pend_id_ff;
   logic           pend_found_ff;
   logic [1:0]     pend_status_ff;
   logic [4:0]     res_id_ff;
   logic           res_found_ff;
   logic [1:0]     res_status_ff;
   logic           res_none_ff;

   logic [TW-1:0]  tid_wide;
   logic [IDW-1:0] rd_id;
   logic [IX-1:0]  cur_ix, rd_ix;
   logic           q_full, fs_full;

   assign tid_wide = TW'(req_task_id);
   assign cur_ix   = IX'(cur_id_ff - IDW'(1));
   assign rd_id    = ctl.ts_rd_rq ? rq_rdata_ff : cur_id_ff;
   assign rd_ix    = IX'(rd_id - IDW'(1));
   assign q_full   = (qcount_ff >= CW'(MAX_TASKS));
   assign fs_full  = (fcount_ff >= CW'(MAX_TASKS));

   always_comb begin
      sts.cmd         = cmd_ff;
      sts.tid_ok      = tid_ok_ff;
      sts.live_full   = (live_ff >= CW'(MAX_TASKS));
      sts.fs_empty    = (fcount_ff == '0);
      sts.fresh_ok    = (fresh_ff <= FW'(MAX_TASKS));
      sts.budget_zero = (budget_ff == '0);
      sts.cur_ok      = (cur_id_ff != '0) && (cur_id_ff <= IDW'(MAX_TASKS));
      sts.st          = ts_rvalid_ff ? rrts_pkg::tstate_type'(ts_rdata_ff)
                                     : rrts_pkg::TS_FREE;
   end

   // memories
   always_ff @(posedge clock) begin
      if (ctl.q_push && !q_full) begin
         rq_mem[tail_ff] <= cur_id_ff;
      end
      if (ctl.rq_pop) begin
         rq_rdata_ff <= rq_mem[head_ff];
      end
      if (ctl.fs_push && !fs_full) begin
         fs_mem[IX'(fcount_ff)] <= cur_id_ff;
      end
      if (ctl.fs_pop) begin
         fs_rdata_ff <= fs_mem[IX'(fcount_ff - CW'(1))];
      end
      if (ctl.ts_wr) begin
         ts_mem[cur_ix] <= ctl.ts_wr_val;
      end
      if (ctl.ts_rd) begin
         ts_rdata_ff  <= ts_mem[rd_ix];
         ts_rvalid_ff <= ts_valid_ff[rd_ix];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ts_valid_ff <= '0;
         head_ff     <= '0;
         tail_ff     <= '0;
         qcount_ff   <= '0;
         fcount_ff   <= '0;
         live_ff     <= '0;
         budget_ff   <= '0;
         fresh_ff    <= FW'(1);
      end else begin
         if (ctl.ts_wr) begin
            ts_valid_ff[cur_ix] <= 1'b1;
         end
         if (ctl.walk_start) begin
            budget_ff <= qcount_ff;
         end
         if (ctl.rq_pop) begin
            head_ff   <= (head_ff == IX'(MAX_TASKS - 1)) ? '0 : head_ff + IX'(1);
            qcount_ff <= qcount_ff - CW'(1);
            budget_ff <= budget_ff - CW'(1);
         end else if (ctl.q_push && !q_full) begin
            tail_ff   <= (tail_ff == IX'(MAX_TASKS - 1)) ? '0 : tail_ff + IX'(1);
            qcount_ff <= qcount_ff + CW'(1);
         end
         if (ctl.fs_pop) begin
            fcount_ff <= fcount_ff - CW'(1);
         end else if (ctl.fs_push && !fs_full) begin
            fcount_ff <= fcount_ff + CW'(1);
         end
         if (ctl.add_fresh) begin
            fresh_ff <= fresh_ff + FW'(1);
         end
         if (ctl.live_inc) begin
            live_ff <= live_ff + CW'(1);
         end else if (ctl.live_dec && live_ff != '0) begin
            live_ff <= live_ff - CW'(1);
         end
      end
   end

   // item registers and result staging
   always_ff @(posedge clock) begin
      if (ctl.latch) begin
         cmd_ff    <= req_command;
         tid_ok_ff <= (tid_wide != '0) && (tid_wide <= TW'(MAX_TASKS));
         cur_id_ff <= IDW'(tid_wide);
      end else if (ctl.add_fresh) begin
         cur_id_ff <= IDW'(fresh_ff);
      end else if (ctl.id_from_fs) begin
         cur_id_ff <= fs_rdata_ff;
      end else if (ctl.id_from_rq) begin
         cur_id_ff <= rq_rdata_ff;
      end
      if (ctl.res_set) begin
         pend_id_ff     <= ctl.res_found ? cur_id_ff : '0;
         pend_found_ff  <= ctl.res_found;
         pend_status_ff <= ctl.res_status;
      end
      if (ctl.rsp_load) begin
         res_id_ff     <= 5'(pend_id_ff);
         res_found_ff  <= pend_found_ff;
         res_status_ff <= pend_status_ff;
         res_none_ff   <= (live_ff == '0);
      end
   end

   assign rsp_result_id     = res_id_ff;
   assign rsp_found         = res_found_ff;
   assign rsp_status        = res_status_ff;
   assign rsp_no_tasks_live = res_none_ff;

endmodule

[rtl/rrts_ctrl.sv]
// scheduler controller: one-hot sequencer over add, next walk and state changes
// depends on rrts_pkg
`timescale 1ns / 1ps
module rrts_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  rrts_pkg::sts_type sts,
   output rrts_pkg::ctl_type ctl
);

   typedef enum logic [8:0] {
      S_IDLE      = 9'b000000001,
      S_DECODE    = 9'b000000010,
      S_ADD_ID    = 9'b000000100,
      S_ADD_WR    = 9'b000001000,
      S_CHK       = 9'b000010000,
      S_WALK_LOOP = 9'b000100000,
      S_WALK_ID   = 9'b001000000,
      S_WALK_ST   = 9'b010000000,
      S_DONE      = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      ctl      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.latch = 1'b1;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (sts.cmd) inside
               rrts_pkg::CMD_ADD: begin
                  if (sts.live_full) begin
                     ctl.res_set    = 1'b1;
                     ctl.res_status = rrts_pkg::STAT_FULL;
                     state_in       = S_DONE;
                  end else if (!sts.fs_empty) begin
                     ctl.fs_pop = 1'b1;
                     state_in   = S_ADD_ID;
                  end else if (sts.fresh_ok) begin
                     ctl.add_fresh = 1'b1;
                     state_in      = S_ADD_WR;
                  end else begin
                     ctl.res_set    = 1'b1;
                     ctl.res_status = rrts_pkg::STAT_FULL;
                     state_in       = S_DONE;
                  end
               end
               rrts_pkg::CMD_NEXT: begin
                  ctl.walk_start = 1'b1;
                  state_in       = S_WALK_LOOP;
               end
               rrts_pkg::CMD_YIELD, rrts_pkg::CMD_SLEEP,
               rrts_pkg::CMD_WAKEUP, rrts_pkg::CMD_EXIT: begin
                  if (!sts.tid_ok) begin
                     ctl.res_set    = 1'b1;
                     ctl.res_status = rrts_pkg::STAT_BAD;
                     state_in       = S_DONE;
                  end else begin
                     ctl.ts_rd = 1'b1;
                     state_in  = S_CHK;
                  end
               end
               default: begin
                  ctl.res_set    = 1'b1;
                  ctl.res_status = rrts_pkg::STAT_OK;
                  state_in       = S_DONE;
               end
            endcase
         end
         S_ADD_ID: begin
            ctl.id_from_fs = 1'b1;
            state_in       = S_ADD_WR;
         end
         S_ADD_WR: begin
            ctl.res_set = 1'b1;
            if (sts.cur_ok) begin
               ctl.ts_wr      = 1'b1;
               ctl.ts_wr_val  = rrts_pkg::TS_NEW;
               ctl.live_inc   = 1'b1;
               ctl.q_push     = 1'b1;
               ctl.res_found  = 1'b1;
               ctl.res_status = rrts_pkg::STAT_OK;
            end else begin
               ctl.res_status = rrts_pkg::STAT_FULL;
            end
            state_in = S_DONE;
         end
         S_CHK: begin
            ctl.res_set    = 1'b1;
            ctl.res_status = rrts_pkg::STAT_OK;
            state_in       = S_DONE;
            if (sts.cmd == rrts_pkg::CMD_WAKEUP) begin
               if (sts.st == rrts_pkg::TS_SLEEP) begin
                  ctl.ts_wr     = 1'b1;
                  ctl.ts_wr_val = rrts_pkg::TS_READY;
                  ctl.q_push    = 1'b1;
               end else begin
                  ctl.res_status = rrts_pkg::STAT_BAD;
               end
            end else if (sts.st != rrts_pkg::TS_ACTIVE) begin
               ctl.res_status = rrts_pkg::STAT_BAD;
            end else begin
               ctl.ts_wr = 1'b1;
               case (sts.cmd)
                  rrts_pkg::CMD_YIELD: begin
                     ctl.ts_wr_val = rrts_pkg::TS_READY;
                     ctl.q_push    = 1'b1;
                  end
                  rrts_pkg::CMD_SLEEP: begin
                     ctl.ts_wr_val = rrts_pkg::TS_SLEEP;
                  end
                  default: begin
                     ctl.ts_wr_val = rrts_pkg::TS_EXITED;
                     ctl.q_push    = 1'b1;
                  end
               endcase
            end
         end
         S_WALK_LOOP: begin
            if (sts.budget_zero) begin
               ctl.res_set    = 1'b1;
               ctl.res_status = rrts_pkg::STAT_NONE_RUN;
               state_in       = S_DONE;
            end else begin
               ctl.rq_pop = 1'b1;
               state_in   = S_WALK_ID;
            end
         end
         S_WALK_ID: begin
            ctl.ts_rd      = 1'b1;
            ctl.ts_rd_rq   = 1'b1;
            ctl.id_from_rq = 1'b1;
            state_in       = S_WALK_ST;
         end
         S_WALK_ST: begin
            state_in = S_WALK_LOOP;
            if (sts.cur_ok) begin
               case (sts.st) inside
                  rrts_pkg::TS_NEW, rrts_pkg::TS_READY: begin
                     ctl.ts_wr      = 1'b1;
                     ctl.ts_wr_val  = rrts_pkg::TS_ACTIVE;
                     ctl.res_set    = 1'b1;
                     ctl.res_found  = 1'b1;
                     ctl.res_status = rrts_pkg::STAT_OK;
                     state_in       = S_DONE;
                  end
                  rrts_pkg::TS_EXITED: begin
                     ctl.ts_wr     = 1'b1;
                     ctl.ts_wr_val = rrts_pkg::TS_FREE;
                     ctl.fs_push   = 1'b1;
                     ctl.live_dec  = 1'b1;
                  end
                  rrts_pkg::TS_FREE: begin
                  end
                  default: begin
                     ctl.q_push = 1'b1;
                  end
               endcase
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               ctl.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

endmodule

[test/round_robin_task_scheduler_test.sv]
// testbench for round_robin_task_scheduler: directed and random command streams
// predicts each response with a local scheduler model; depends on rrts_pkg and the rtl
`timescale 1ns / 1ps
module round_robin_task_scheduler_test;

   localparam int NTASK = 16;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int EXP_DEPTH = 64;

   typedef struct packed {
      logic [4:0] result_id;
      logic       found;
      logic [1:0] status;
      logic       no_tasks_live;
   } sched_rsp_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [2:0] req_command = '0;
   logic [4:0] req_task_id = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [4:0] rsp_result_id;
   logic       rsp_found;
   logic [1:0] rsp_status;
   logic       rsp_no_tasks_live;

   round_robin_task_scheduler #(.MAX_TASKS(NTASK)) i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_command(req_command), .req_task_id(req_task_id),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_result_id(rsp_result_id), .rsp_found(rsp_found),
      .rsp_status(rsp_status), .rsp_no_tasks_live(rsp_no_tasks_live)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // scheduler shadow state
   rrts_pkg::tstate_type task_st[NTASK];
   logic [4:0] runq[NTASK];
   int         rq_head, rq_tail, rq_count;
   logic [4:0] free_ids[NTASK];
   int         free_cnt, fresh_id, live_cnt;

   // expected responses in transfer order
   sched_rsp_type exp_mem[EXP_DEPTH];
   int         exp_wr = 0;
   int         exp_rd = 0;
   int         err_count = 0;
   int         send_idle_pct = 0;
   int         recv_stall_pct = 0;
   bit         hold_rsp = 1'b0;
   int         idle_cycles = 0;

   function automatic void sched_init();
      for (int i = 0; i < NTASK; i++) begin
         task_st[i] = rrts_pkg::TS_FREE;
         runq[i] = '0;
         free_ids[i] = '0;
      end
      rq_head = 0; rq_tail = 0; rq_count = 0;
      free_cnt = 0; fresh_id = 1; live_cnt = 0;
   endfunction

   function automatic void runq_push(logic [4:0] id);
      if (rq_count < NTASK) begin
         runq[rq_tail] = id;
         rq_tail = (rq_tail + 1) % NTASK;
         rq_count++;
      end
   endfunction

   function automatic sched_rsp_type sched_step(logic [2:0] cmd, logic [4:0] tid);
      sched_rsp_type r;
      int         id, budget;
      bit         tid_ok;
      r = '0;
      tid_ok = (tid >= 1 && tid <= NTASK);
      case (cmd)
         rrts_pkg::CMD_ADD: begin
            id = 0;
            if (live_cnt >= NTASK) r.status = rrts_pkg::STAT_FULL;
            else if (free_cnt > 0) begin
               free_cnt--;
               id = free_ids[free_cnt];
            end else if (fresh_id <= NTASK) begin
               id = fresh_id;
               fresh_id++;
            end else r.status = rrts_pkg::STAT_FULL;
            if (r.status == rrts_pkg::STAT_OK && id >= 1 && id <= NTASK) begin
               task_st[id-1] = rrts_pkg::TS_NEW;
               live_cnt++;
               runq_push(id[4:0]);
               r.result_id = id[4:0];
               r.found = 1'b1;
            end else if (r.status == rrts_pkg::STAT_OK) r.status = rrts_pkg::STAT_FULL;
         end
         rrts_pkg::CMD_NEXT: begin
            budget = rq_count;
            while (budget > 0 && !r.found) begin
               id = runq[rq_head];
               rq_head = (rq_head + 1) % NTASK;
               rq_count--;
               budget--;
               if (id >= 1 && id <= NTASK) begin
                  if (task_st[id-1] == rrts_pkg::TS_NEW ||
                      task_st[id-1] == rrts_pkg::TS_READY) begin
                     task_st[id-1] = rrts_pkg::TS_ACTIVE;
                     r.result_id = id[4:0];
                     r.found = 1'b1;
                  end else if (task_st[id-1] == rrts_pkg::TS_EXITED) begin
                     task_st[id-1] = rrts_pkg::TS_FREE;
                     if (free_cnt < NTASK) begin
                        free_ids[free_cnt] = id[4:0];
                        free_cnt++;
                     end
                     if (live_cnt > 0) live_cnt--;
                  end else if (task_st[id-1] != rrts_pkg::TS_FREE) runq_push(id[4:0]);
               end
            end
            if (!r.found) r.status = rrts_pkg::STAT_NONE_RUN;
         end
         rrts_pkg::CMD_YIELD, rrts_pkg::CMD_SLEEP, rrts_pkg::CMD_WAKEUP,
         rrts_pkg::CMD_EXIT: begin
            if (!tid_ok) r.status = rrts_pkg::STAT_BAD;
            else if (cmd == rrts_pkg::CMD_WAKEUP) begin
               if (task_st[tid-1] == rrts_pkg::TS_SLEEP) begin
                  task_st[tid-1] = rrts_pkg::TS_READY;
                  runq_push(tid);
               end else r.status = rrts_pkg::STAT_BAD;
            end else if (task_st[tid-1] != rrts_pkg::TS_ACTIVE) r.status = rrts_pkg::STAT_BAD;
            else if (cmd == rrts_pkg::CMD_YIELD) begin
               task_st[tid-1] = rrts_pkg::TS_READY;
               runq_push(tid);
            end else if (cmd == rrts_pkg::CMD_SLEEP) task_st[tid-1] = rrts_pkg::TS_SLEEP;
            else begin
               task_st[tid-1] = rrts_pkg::TS_EXITED;
               runq_push(tid);
            end
         end
         default: ;
      endcase
      r.no_tasks_live = (live_cnt == 0);
      return r;
   endfunction

   // sender: one transfer per call, random idle before it
   task automatic send_cmd(logic [2:0] cmd, logic [4:0] tid);
      @(posedge clock);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(posedge clock);
      req_valid <= 1'b1;
      req_command <= cmd;
      req_task_id <= tid;
      do @(posedge clock); while (!req_ready);
      exp_mem[exp_wr % EXP_DEPTH] = sched_step(cmd, tid);
      exp_wr++;
      req_valid <= 1'b0;
   endtask

   // receiver ready
   always @(posedge clock) begin
      if (reset || hold_rsp) rsp_ready <= 1'b0;
      else rsp_ready <= !($urandom_range(99) < recv_stall_pct);
   end

   // response checker
   always @(posedge clock) begin
      sched_rsp_type got, exp;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_result_id, rsp_found, rsp_status, rsp_no_tasks_live};
         if (exp_wr == exp_rd) begin
            err_count++;
            if (err_count <= 10) $display("unexpected response %p", got);
         end else begin
            exp = exp_mem[exp_rd % EXP_DEPTH];
            exp_rd++;
            if (got !== exp) begin
               err_count++;
               if (err_count <= 10) $display("mismatch: expected %p got %p", exp, got);
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (!reset && idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic drain();
      while (exp_wr != exp_rd) @(posedge clock);
   endtask

   function automatic logic [4:0] pick_live_id();
      if ($urandom_range(9) == 0) return 5'($urandom_range(31));
      return 5'($urandom_range(NTASK, 1));
   endfunction

   task automatic test_directed();
      send_cmd(rrts_pkg::CMD_NEXT, 5'd0);
      send_cmd(rrts_pkg::CMD_YIELD, 5'd0);
      send_cmd(rrts_pkg::CMD_WAKEUP, 5'd31);
      send_cmd(rrts_pkg::CMD_EXIT, 5'd17);
      send_cmd(3'd6, 5'd21);
      send_cmd(3'd7, 5'd10);
      for (int i = 0; i < NTASK + 1; i++)
         send_cmd(rrts_pkg::CMD_ADD, 5'($urandom_range(31)));
      send_cmd(rrts_pkg::CMD_NEXT, 5'd0);
      send_cmd(rrts_pkg::CMD_SLEEP, 5'd1);
      send_cmd(rrts_pkg::CMD_WAKEUP, 5'd1);
      drain();
   endtask

   // mostly next followed by an action on the dispatched task
   task automatic test_random(int count);
      int         sel;
      logic [4:0] tid;
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(99);
         if (sel < 20) send_cmd(rrts_pkg::CMD_ADD, 5'($urandom_range(31)));
         else if (sel < 75) begin
            send_cmd(rrts_pkg::CMD_NEXT, 5'($urandom_range(31)));
            drain();
            tid = pick_live_id();
            for (int i = 0; i < NTASK; i++)
               if (task_st[i] == rrts_pkg::TS_ACTIVE && $urandom_range(1)) tid = 5'(i + 1);
            case ($urandom_range(3))
               0: send_cmd(rrts_pkg::CMD_YIELD, tid);
               1: send_cmd(rrts_pkg::CMD_SLEEP, tid);
               2: send_cmd(rrts_pkg::CMD_EXIT, tid);
               default: send_cmd(rrts_pkg::CMD_NEXT, tid);
            endcase
            n++;
         end else if (sel < 90) send_cmd(rrts_pkg::CMD_WAKEUP, pick_live_id());
         else send_cmd(3'($urandom_range(7)), 5'($urandom_range(31)));
      end
      drain();
   endtask

   task automatic test_backpressure();
      fork
         begin
            hold_rsp = 1'b1;
            repeat (200) @(posedge clock);
            hold_rsp = 1'b0;
         end
         for (int i = 0; i < 8; i++) send_cmd(3'($urandom_range(5)), pick_live_id());
      join
      drain();
   endtask

   initial begin
      sched_init();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(110);
      send_idle_pct = 66;
      test_random(110);
      send_idle_pct = 0; recv_stall_pct = 66;
      test_random(110);
      send_idle_pct = 28; recv_stall_pct = 28;
      test_random(110);
      send_idle_pct = 0; recv_stall_pct = 0;
      test_backpressure();
      test_random(40);
      repeat (200) @(posedge clock);
      if (err_count == 0 && exp_wr == exp_rd) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end
endmodule
